[src/rtmf_pkg.sv]
// Shared types, sizes and operation codes for the recency table unit.
package rtmf_pkg;

  // Table depth and derived widths
  localparam int DEPTH  = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EXT_W  = CNT_W + 1;
  localparam int FILL_W = 6;

  // Port word sizes
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // One table entry, stamp in the top bits
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] total;
    logic [31:0] page;
    logic [63:0] key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    op_t         req_type;
    logic [63:0] key;
    logic [31:0] page;
    logic [31:0] total;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [31:0]       hit_page;
    logic [31:0]       hit_total;
    logic [31:0]       hit_stamp;
    logic [FILL_W-1:0] fill;
  } res_t;

  // Result handoff from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    res_t res;
  } core_res_t;

endpackage

[src/rtmf_ram.sv]
// Simple dual-port table RAM with registered read data.
module rtmf_ram #(
  parameter int DEPTH_P  = 32,
  parameter int WIDTH_P  = 160,
  parameter int ADDR_W_P = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W_P-1:0] waddr,
  input  logic [WIDTH_P-1:0]  wdata,
  input  logic                re,
  input  logic [ADDR_W_P-1:0] raddr,
  output logic [WIDTH_P-1:0]  rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // Write on we, hold read data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rtmf_core.sv]
// Sequencer that scans, shifts and rewrites the table through one compare unit.
module rtmf_core import rtmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  req_t      req_in,
  output logic      req_ready,
  output core_res_t res_out,
  input  logic      res_ready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_RESOLVE,
    ST_SH_RD,
    ST_SH_WR,
    ST_HEAD,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             found_r, found_nxt;
  req_t             req_r, req_nxt;
  logic             status_r, status_nxt;
  slot_t            hit_r, hit_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t            rd_slot;

  logic [EXT_W-1:0] j_ext, used_ext;
  logic             full;
  logic [IDX_W-1:0] ins_pos;
  slot_t            new_slot;

  assign rd_slot  = slot_t'(ram_rdata);
  assign j_ext    = EXT_W'(j_r);
  assign used_ext = EXT_W'(used_r);
  assign full     = (used_ext == EXT_W'(DEPTH));
  assign ins_pos  = full ? IDX_W'(DEPTH - 1) : used_r[IDX_W-1:0];

  assign new_slot.key   = req_r.key;
  assign new_slot.page  = req_r.page;
  assign new_slot.total = req_r.total;
  assign new_slot.stamp = req_r.stamp;

  rtmf_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (SLOT_W),
    .ADDR_W_P(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequence one request: scan for the key, then shift entries one word a step
  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    used_nxt   = used_r;
    found_nxt  = found_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = j_r;
    ram_wdata  = rd_slot;
    ram_raddr  = j_r;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt    = req_in;
          j_nxt      = '0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          hit_nxt    = '0;
          if (req_in.req_type == OP_CLEAR) begin
            used_nxt  = '0;
            state_nxt = ST_DONE;
          end else if (used_r == '0) begin
            state_nxt = ST_RESOLVE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_slot.key == req_r.key) begin
          found_nxt = 1'b1;
          state_nxt = ST_RESOLVE;
        end else if (j_ext + EXT_W'(1) == used_ext) begin
          found_nxt = 1'b0;
          state_nxt = ST_RESOLVE;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_RESOLVE: begin
        case (req_r.req_type)
          OP_FIND: begin
            if (found_r) begin
              hit_nxt = rd_slot;
            end else begin
              status_nxt = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          OP_REMOVE: begin
            if (!found_r) begin
              status_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end else if (j_ext + EXT_W'(1) < used_ext) begin
              state_nxt = ST_SH_RD;
            end else begin
              used_nxt  = used_r - CNT_W'(1);
              state_nxt = ST_DONE;
            end
          end
          OP_UPDATE: begin
            if (found_r) begin
              state_nxt = (j_r == '0) ? ST_HEAD : ST_SH_RD;
            end else begin
              j_nxt     = ins_pos;
              used_nxt  = full ? used_r : used_r + CNT_W'(1);
              state_nxt = (ins_pos == '0) ? ST_HEAD : ST_SH_RD;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (req_r.req_type == OP_UPDATE) ? j_r - IDX_W'(1) : j_r + IDX_W'(1);
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        ram_we = 1'b1;
        if (req_r.req_type == OP_UPDATE) begin
          j_nxt     = j_r - IDX_W'(1);
          state_nxt = (j_r == IDX_W'(1)) ? ST_HEAD : ST_SH_RD;
        end else begin
          j_nxt = j_r + IDX_W'(1);
          if (j_ext + EXT_W'(2) < used_ext) begin
            state_nxt = ST_SH_RD;
          end else begin
            used_nxt  = used_r - CNT_W'(1);
            state_nxt = ST_DONE;
          end
        end
      end
      ST_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_slot;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, table count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      j_r      <= j_nxt;
      found_r  <= found_nxt;
      req_r    <= req_nxt;
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign req_ready               = (state_r == ST_IDLE);
  assign res_out.valid           = (state_r == ST_DONE);
  assign res_out.res.status      = status_r;
  assign res_out.res.hit_page    = hit_r.page;
  assign res_out.res.hit_total   = hit_r.total;
  assign res_out.res.hit_stamp   = hit_r.stamp;
  assign res_out.res.fill        = FILL_W'(used_r);

endmodule

[src/recency_table_move_to_front_unit.sv]
// Top level of the move-to-front recency table: stream ports and output register.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------
//   in_      | slave     | in_tvalid/in_tready | tdata key,page,total,stamp; tuser op
//   out_     | master    | out_tvalid/tready   | tdata page,total,stamp,fill; tuser st
//
// Clear goes straight to its result. Other requests compare stored keys one by one
// (none on an empty table), then move entries one by one and, for an update, write
// the head; one key comparator and the single read port of the table RAM set the pace.
// rst_n is synchronous: the table count and sequencer reset, entries need no clear.
// A new word is taken once the previous result is in the output register, even
// while that result waits for out_tready.
module recency_table_move_to_front_unit import rtmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key[63:0], page[95:64], total[127:96], stamp[159:128]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit_page[31:0], hit_total[63:32], hit_stamp[95:64], fill[101:96], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  output logic [OUT_USER_W-1:0] out_tuser
);

  req_t      req;
  core_res_t core_res;
  logic      res_ready;
  logic      out_valid_r;
  res_t      out_res_r;

  // Unpack the request word
  assign req.req_type = op_t'(in_tuser);
  assign req.key      = in_tdata[63:0];
  assign req.page     = in_tdata[95:64];
  assign req.total    = in_tdata[127:96];
  assign req.stamp    = in_tdata[159:128];

  rtmf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_in   (req),
    .req_ready(in_tready),
    .res_out  (core_res),
    .res_ready(res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= core_res.valid;
      if (core_res.valid) begin
        out_res_r <= core_res.res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 102)'(0), out_res_r.fill, out_res_r.hit_stamp,
                       out_res_r.hit_total, out_res_r.hit_page};
  assign out_tuser  = out_res_r.status;

endmodule

[src/rtmf_chk.sv]
// Port checker for the recency table unit, bound to the top level.
module rtmf_chk import rtmf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Ready is low in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while the sequencer was busy");

  // A miss carries zero hit fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:0] == '0)
    else $error("miss result with nonzero hit fields");

  // Keep the fill count within the table depth
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 63) || (int'(out_tdata[101:96]) <= DEPTH))
    else $error("fill count beyond table depth");

endmodule

bind recency_table_move_to_front_unit rtmf_chk u_rtmf_chk (.*);

[dv/recency_table_move_to_front_unit_check.sv]
// Result checker for the recency table unit: tracks the list and compares result words.
module recency_table_move_to_front_unit_check import rtmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // key[63:0], page[95:64], total[127:96], stamp[159:128]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // hit_page[31:0], hit_total[63:32], hit_stamp[95:64], fill[101:96], zero pad
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  input  logic [OUT_USER_W-1:0] out_tuser,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the table, most recent entry at index zero
  slot_t       recency_list [DEPTH];
  int unsigned entry_count;
  res_t        awaited_results [$];

  // Position of the entry nearest the front that holds key, -1 when absent
  function automatic int position_of(logic [63:0] key);
    for (int i = 0; i < int'(entry_count); i++) begin
      if (recency_list[i].key == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the mirror and return the result word it should give
  function automatic res_t apply_request(op_t op, logic [63:0] key, logic [31:0] page,
                                         logic [31:0] total, logic [31:0] stamp);
    res_t r;
    int   pos;
    r = '0;
    case (op)
      OP_UPDATE: begin
        pos = position_of(key);
        if (pos < 0) begin
          // full table: the oldest entry falls off the end
          if (entry_count >= DEPTH) entry_count = DEPTH - 1;
          pos = int'(entry_count);
          entry_count++;
        end
        for (int i = pos; i > 0; i--) recency_list[i] = recency_list[i-1];
        recency_list[0].key   = key;
        recency_list[0].page  = page;
        recency_list[0].total = total;
        recency_list[0].stamp = stamp;
      end
      OP_REMOVE: begin
        pos = position_of(key);
        if (pos < 0) begin
          r.status = 1'b1;
        end else begin
          // close the gap behind the removed entry
          for (int i = pos; i + 1 < int'(entry_count); i++) recency_list[i] = recency_list[i+1];
          entry_count--;
        end
      end
      OP_CLEAR: begin
        entry_count = 0;
      end
      default: begin
        pos = position_of(key);
        if (pos < 0) begin
          r.status = 1'b1;
        end else begin
          r.hit_page  = recency_list[pos].page;
          r.hit_total = recency_list[pos].total;
          r.hit_stamp = recency_list[pos].stamp;
        end
      end
    endcase
    r.fill = FILL_W'(entry_count);
    return r;
  endfunction

  // Compare result words first: a word accepted now cannot belong to this edge's request
  always @(posedge clk) begin : track
    res_t want;
    res_t seen;
    int   errs;
    errs = 0;
    if (!rst_n) begin
      entry_count = 0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status    = out_tuser[0];
        seen.hit_page  = out_tdata[31:0];
        seen.hit_total = out_tdata[63:32];
        seen.hit_stamp = out_tdata[95:64];
        seen.fill      = out_tdata[96 +: FILL_W];
        if (awaited_results.size() == 0) begin
          $error("result word with no request outstanding: status %0d, fill %0d",
                 seen.status, seen.fill);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            errs++;
          end
          if (seen.hit_page !== want.hit_page) begin
            $error("hit_page: expected %h, got %h", want.hit_page, seen.hit_page);
            errs++;
          end
          if (seen.hit_total !== want.hit_total) begin
            $error("hit_total: expected %h, got %h", want.hit_total, seen.hit_total);
            errs++;
          end
          if (seen.hit_stamp !== want.hit_stamp) begin
            $error("hit_stamp: expected %h, got %h", want.hit_stamp, seen.hit_stamp);
            errs++;
          end
          if (seen.fill !== want.fill) begin
            $error("fill: expected %0d, got %0d", want.fill, seen.fill);
            errs++;
          end
          if (out_tdata[OUT_DATA_W-1:96+FILL_W] !== '0) begin
            $error("pad: expected 0, got %h", out_tdata[OUT_DATA_W-1:96+FILL_W]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_request(op_t'(in_tuser[1:0]), in_tdata[63:0],
                                                in_tdata[95:64], in_tdata[127:96],
                                                in_tdata[159:128]));
      end
    end
    mismatches  <= mismatches + errs;
    outstanding <= awaited_results.size();
  end

endmodule

[dv/recency_table_move_to_front_unit_test.sv]
// Testbench top for the recency table unit: clock, reset, request traffic and verdict.
module recency_table_move_to_front_unit_test import rtmf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch without any accepted word before the run is declared hung
  localparam int IDLE_LIMIT   = 2000;
  // Slowest request: full search plus full shift, with margin
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  localparam int WORD_TARGET  = 500;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int mismatches;
  int outstanding;
  int words_sent  = 0;
  int quiet_count = 0;
  int stall_left  = 0;
  bit in_calm     = 1'b0;
  bit out_calm    = 1'b0;

  recency_table_move_to_front_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  recency_table_move_to_front_unit_check table_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial forever #2 clk = ~clk;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int gap_cycles();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request word, hold it until taken, then idle for a random gap
  task automatic send_request(input op_t op, input logic [63:0] key, input logic [31:0] page,
                              input logic [31:0] total, input logic [31:0] stamp);
    int gap;
    in_tdata  <= {stamp, total, page, key};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side backpressure, with calm stretches now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) out_calm <= ~out_calm;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!out_calm && $urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 3);
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] key_pool [$];
    logic [63:0] k;
    op_t         op;
    int          pool_n;
    int          span;
    int          r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: absent find and remove, clear with nothing to clear
    send_request(OP_FIND,   64'h0123_4567_89ab_cdef, $urandom, $urandom, $urandom);
    send_request(OP_REMOVE, 64'h0123_4567_89ab_cdef, $urandom, $urandom, $urandom);
    send_request(OP_CLEAR,  64'h0123_4567_89ab_cdef, $urandom, $urandom, $urandom);
    // Extreme keys and values
    send_request(OP_UPDATE, '0, '0, '0, '0);
    send_request(OP_UPDATE, '1, '1, '1, '1);
    send_request(OP_UPDATE, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h1, 32'h7fff_ffff);
    // Hits in the middle and at the tail, then a one-bit near miss
    send_request(OP_FIND,   '1, $urandom, $urandom, $urandom);
    send_request(OP_FIND,   '0, $urandom, $urandom, $urandom);
    send_request(OP_FIND,   64'h8000_0000_0000_0001, $urandom, $urandom, $urandom);
    // Move the tail entry to the front with new values
    send_request(OP_UPDATE, '0, 32'd5, 32'd6, 32'd7);
    send_request(OP_FIND,   '0, $urandom, $urandom, $urandom);
    // Remove present, then the same key again
    send_request(OP_REMOVE, '1, $urandom, $urandom, $urandom);
    send_request(OP_REMOVE, '1, $urandom, $urandom, $urandom);
    send_request(OP_CLEAR,  '0, $urandom, $urandom, $urandom);
    send_request(OP_FIND,   '0, $urandom, $urandom, $urandom);

    // Random episodes, each on its own key pool
    while (words_sent < WORD_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 3)      pool_n = 3;
      else if (r < 7) pool_n = DEPTH + 8;
      else if (r < 9) pool_n = DEPTH / 2 + 8;
      else            pool_n = 1;
      key_pool.delete();
      for (int i = 0; i < pool_n; i++) begin
        // some keys differ from their neighbor in one bit only
        if (i > 0 && $urandom_range(0, 3) == 0)
          key_pool.push_back(key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63)));
        else
          key_pool.push_back({$urandom, $urandom});
      end
      in_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) send_request(OP_CLEAR, '0, $urandom, $urandom, $urandom);
      span = $urandom_range(20, 80);
      for (int n = 0; n < span && words_sent < WORD_TARGET; n++) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 55)      op = OP_UPDATE;
        else if (r < 75) op = OP_FIND;
        else if (r < 92) op = OP_REMOVE;
        else if (r < 94) op = OP_CLEAR;
        else begin
          // noise: any operation on a key outside the pool
          op = op_t'($urandom_range(0, 3));
          k  = {$urandom, $urandom};
        end
        send_request(op, k, $urandom, $urandom, $urandom);
      end
    end

    // Drain and give the verdict
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[recency_table_move_to_front_unit.f]
src/rtmf_pkg.sv
src/rtmf_ram.sv
src/rtmf_core.sv
src/recency_table_move_to_front_unit.sv
src/rtmf_chk.sv
dv/recency_table_move_to_front_unit_check.sv
dv/recency_table_move_to_front_unit_test.sv
